FILE: hdl/arsel_pkg.sv
// Package for the adaptive roulette selector: sizes, register indexes,
// transaction structs and small helper functions.
// No dependencies.
`default_nettype none

package arsel_pkg;

    // Table geometry and fixed-point formats
    localparam int MAX_ENTRIES     = 32;
    localparam int SCORE_FRAC_BITS = 16;
    localparam int SCORE_BITS      = 8 + SCORE_FRAC_BITS;
    localparam int ADDR_W          = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int SUM_W           = SCORE_BITS + ADDR_W;
    localparam int FRACTION_W      = 16;
    localparam int MULT_W          = 16;
    localparam int MULT_FRAC_BITS  = 12;
    localparam int PROD_W          = SUM_W + FRACTION_W;
    localparam int SCALED_W        = PROD_W - MULT_FRAC_BITS;

    localparam logic [SCORE_BITS-1:0] SCORE_ONE = SCORE_BITS'(1) << SCORE_FRAC_BITS;
    localparam logic [SCORE_BITS-1:0] SCORE_MAX = '1;

    // Field widths fixed by the interface
    localparam int INDEX_W  = 5;
    localparam int OUTCOME_W = 2;
    localparam int ACTIVE_W = 6;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_ADDR_W = 2;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_COUNT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BEST_MULT    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_IMPROVE_MULT = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_WORSE_MULT   = 2'd3;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 6'd32;
    localparam logic [MULT_W-1:0]   MULT_RESET   = 16'd4096;

    // Operation and outcome codes
    localparam logic OP_SELECT = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    localparam logic [OUTCOME_W-1:0] OUT_BEST    = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_IMPROVE = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_WORSE   = 2'd2;
    localparam logic [OUTCOME_W-1:0] OUT_NONE    = 2'd3;

    // Input transaction
    typedef struct packed {
        logic                  operation;
        logic [FRACTION_W-1:0] random_fraction;
        logic [INDEX_W-1:0]    entry_index;
        logic [OUTCOME_W-1:0]  outcome;
    } in_item_t;

    // Result transaction
    typedef struct packed {
        logic [INDEX_W-1:0] chosen_index;
        logic               was_select;
    } out_item_t;

    // Score table write port
    typedef struct packed {
        logic                  en;
        logic [ADDR_W-1:0]     addr;
        logic [SCORE_BITS-1:0] data;
    } mem_wr_t;

    // Last active index: zero count means one entry, clipped at the table depth
    function automatic logic [ADDR_W-1:0] last_index(input logic [ACTIVE_W-1:0] active);
        int n;
        n = int'(active);
        if (n == 0)
            n = 1;
        if (n > MAX_ENTRIES)
            n = MAX_ENTRIES;
        return ADDR_W'(n - 1);
    endfunction

    // Saturate a scaled product to [1, SCORE_MAX]
    function automatic logic [SCORE_BITS-1:0] saturate(input logic [SCALED_W-1:0] p);
        logic [SCORE_BITS-1:0] r;
        if (p > SCALED_W'(SCORE_MAX))
            r = SCORE_MAX;
        else if (p == '0)
            r = SCORE_BITS'(1);
        else
            r = SCORE_BITS'(p);
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/arsel_score_mem.sv
// Score table: single-port-write, single-read memory with registered read
// data and per-entry valid bits so unwritten entries read as 1.0.
// Depends on arsel_pkg.
`default_nettype none

module arsel_score_mem (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire arsel_pkg::mem_wr_t                  wr,
    input  wire logic [arsel_pkg::ADDR_W-1:0]        rd_addr,
    output logic      [arsel_pkg::SCORE_BITS-1:0]    rd_data
);

    logic [arsel_pkg::SCORE_BITS-1:0] mem [arsel_pkg::MAX_ENTRIES];
    logic [arsel_pkg::MAX_ENTRIES-1:0] valid_reg;
    logic [arsel_pkg::SCORE_BITS-1:0] rd_mem_reg;
    logic                             rd_vld_reg;

    // Storage write and registered read
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_mem_reg <= mem[rd_addr];
    end

    // Valid bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            rd_vld_reg <= valid_reg[rd_addr];
        end
    end

    // Entries never written hold the reset score
    assign rd_data = rd_vld_reg ? rd_mem_reg : arsel_pkg::SCORE_ONE;

endmodule

`default_nettype wire

FILE: hdl/adaptive_roulette_selector.sv
// Channel   | Signals                        | Transfer
// ----------+--------------------------------+-------------------------------
// input     | start, busy, item              | start & !busy at rising edge
// result    | done, result                   | done high for one cycle
// config    | cfg_write, cfg_addr, cfg_data  | cfg_write at rising edge
//
// Select: a sum pass and a scan pass each read one entry per cycle, with one
// multiply between them; the sum pass covers the effective active count and
// the scan pass stops at the first hit. busy falls as done rises, and only
// then is the next command accepted. Update: read, multiply, write, then done;
// an update with outcome three is answered the next cycle and busy never rises.
// Asynchronous active-low reset, all scores read 1.0 after it; no result stall.
//
// Top level of the adaptive roulette selector. Depends on arsel_pkg and
// arsel_score_mem.
`default_nettype none

module adaptive_roulette_selector (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire arsel_pkg::in_item_t                  item,
    output logic                                      done,
    output arsel_pkg::out_item_t                      result,
    input  wire logic                                 cfg_write,
    input  wire logic [arsel_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [arsel_pkg::CFG_DATA_W-1:0]     cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_SUM_LAST,
        ST_MUL,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_UPD_RD,
        ST_UPD_MUL,
        ST_UPD_WR
    } state_t;

    // Configuration registers
    logic [arsel_pkg::ACTIVE_W-1:0] active_reg;
    logic [arsel_pkg::MULT_W-1:0]   best_mult_reg;
    logic [arsel_pkg::MULT_W-1:0]   improve_mult_reg;
    logic [arsel_pkg::MULT_W-1:0]   worse_mult_reg;

    // Sequencer state and datapath registers
    state_t                              state_reg, state_next;
    logic [arsel_pkg::ADDR_W-1:0]        cnt_reg, cnt_next;
    logic [arsel_pkg::ADDR_W-1:0]        last_reg, last_next;
    logic [arsel_pkg::ADDR_W-1:0]        data_idx_reg, data_idx_next;
    logic                                pend_reg, pend_next;
    logic [arsel_pkg::SUM_W-1:0]         sum_reg, sum_next;
    logic [arsel_pkg::SUM_W-1:0]         acc_reg, acc_next;
    logic [arsel_pkg::PROD_W-1:0]        prod_reg, prod_next;
    logic                                op_reg, op_next;
    logic [arsel_pkg::FRACTION_W-1:0]    frac_reg, frac_next;
    logic [arsel_pkg::MULT_W-1:0]        mult_reg, mult_next;
    logic [arsel_pkg::INDEX_W-1:0]       idx_reg, idx_next;
    logic                                done_reg, done_next;
    arsel_pkg::out_item_t                result_reg, result_next;

    // Shared multiplier and table access
    logic [arsel_pkg::SUM_W-1:0]         mul_a;
    logic [arsel_pkg::MULT_W-1:0]        mul_b;
    logic [arsel_pkg::PROD_W-1:0]        mul_p;
    logic [arsel_pkg::ADDR_W-1:0]        rd_addr;
    logic [arsel_pkg::SCORE_BITS-1:0]    rd_data;
    arsel_pkg::mem_wr_t                  mem_wr;
    logic [arsel_pkg::SUM_W-1:0]         acc_new;
    logic [arsel_pkg::SUM_W-1:0]         target;
    logic                                hit;
    logic                                accept;
    logic                                upd_ok;

    assign accept = start && !busy;

    // Update applies only to an in-range entry with a real outcome
    assign upd_ok = (int'(item.entry_index) < arsel_pkg::MAX_ENTRIES) &&
                    (item.outcome != arsel_pkg::OUT_NONE);

    arsel_score_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (mem_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg       <= arsel_pkg::ACTIVE_RESET;
            best_mult_reg    <= arsel_pkg::MULT_RESET;
            improve_mult_reg <= arsel_pkg::MULT_RESET;
            worse_mult_reg   <= arsel_pkg::MULT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_addr)
                arsel_pkg::REG_ACTIVE_COUNT:
                    active_reg <= cfg_data[arsel_pkg::ACTIVE_W-1:0];
                arsel_pkg::REG_BEST_MULT:
                    best_mult_reg <= cfg_data;
                arsel_pkg::REG_IMPROVE_MULT:
                    improve_mult_reg <= cfg_data;
                arsel_pkg::REG_WORSE_MULT:
                    worse_mult_reg <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    // Multiplier: total times fraction for select, score times factor for update
    always_comb
    begin
        if (state_reg == ST_UPD_MUL)
        begin
            mul_a = arsel_pkg::SUM_W'(rd_data);
            mul_b = mult_reg;
        end
        else
        begin
            mul_a = sum_reg;
            mul_b = frac_reg;
        end
        mul_p = arsel_pkg::PROD_W'(mul_a) * arsel_pkg::PROD_W'(mul_b);
    end

    // Prefix compare against the scaled target
    assign acc_new = acc_reg + arsel_pkg::SUM_W'(rd_data);
    assign target  = prod_reg[arsel_pkg::PROD_W-1:arsel_pkg::FRACTION_W];
    assign hit     = target <= acc_new;

    // Table read address
    always_comb
    begin
        if (state_reg == ST_UPD_RD)
            rd_addr = arsel_pkg::ADDR_W'(idx_reg);
        else
            rd_addr = cnt_reg;
    end

    // Table write on the last update step
    always_comb
    begin
        mem_wr.en   = (state_reg == ST_UPD_WR);
        mem_wr.addr = arsel_pkg::ADDR_W'(idx_reg);
        mem_wr.data = arsel_pkg::saturate(
                          prod_reg[arsel_pkg::PROD_W-1:arsel_pkg::MULT_FRAC_BITS]);
    end

    // Sequencer next state
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        last_next     = last_reg;
        data_idx_next = data_idx_reg;
        pend_next     = pend_reg;
        sum_next      = sum_reg;
        acc_next      = acc_reg;
        prod_next     = prod_reg;
        op_next       = op_reg;
        frac_next     = frac_reg;
        mult_next     = mult_reg;
        idx_next      = idx_reg;
        done_next     = 1'b0;
        result_next   = result_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next   = item.operation;
                    frac_next = item.random_fraction;
                    idx_next  = item.entry_index;
                    last_next = arsel_pkg::last_index(active_reg);
                    cnt_next  = '0;
                    pend_next = 1'b0;
                    sum_next  = '0;
                    unique case (item.outcome)
                        arsel_pkg::OUT_BEST:    mult_next = best_mult_reg;
                        arsel_pkg::OUT_IMPROVE: mult_next = improve_mult_reg;
                        default:                mult_next = worse_mult_reg;
                    endcase
                    if (item.operation == arsel_pkg::OP_SELECT)
                    begin
                        state_next = ST_SUM;
                    end
                    else if (upd_ok)
                    begin
                        state_next = ST_UPD_RD;
                    end
                    else
                    begin
                        // Nothing to change: answer at once
                        done_next                = 1'b1;
                        result_next.chosen_index = item.entry_index;
                        result_next.was_select   = 1'b0;
                    end
                end
            end

            // First pass: total of active scores
            ST_SUM:
            begin
                if (pend_reg)
                    sum_next = sum_reg + arsel_pkg::SUM_W'(rd_data);
                pend_next = 1'b1;
                if (cnt_reg == last_reg)
                    state_next = ST_SUM_LAST;
                else
                    cnt_next = cnt_reg + 1'b1;
            end

            ST_SUM_LAST:
            begin
                sum_next   = sum_reg + arsel_pkg::SUM_W'(rd_data);
                state_next = ST_MUL;
            end

            ST_MUL:
            begin
                prod_next  = mul_p;
                cnt_next   = '0;
                acc_next   = '0;
                pend_next  = 1'b0;
                state_next = ST_SCAN;
            end

            // Second pass: first prefix sum reaching the target
            ST_SCAN:
            begin
                data_idx_next = cnt_reg;
                pend_next     = 1'b1;
                if (pend_reg)
                    acc_next = acc_new;
                if (pend_reg && hit)
                begin
                    done_next                = 1'b1;
                    result_next.chosen_index = arsel_pkg::INDEX_W'(data_idx_reg);
                    result_next.was_select   = 1'b1;
                    state_next               = ST_IDLE;
                end
                else if (cnt_reg == last_reg)
                begin
                    state_next = ST_SCAN_LAST;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            // Last entry wins whether or not it reaches the target
            ST_SCAN_LAST:
            begin
                done_next                = 1'b1;
                result_next.chosen_index = arsel_pkg::INDEX_W'(last_reg);
                result_next.was_select   = 1'b1;
                state_next               = ST_IDLE;
            end

            ST_UPD_RD:
            begin
                state_next = ST_UPD_MUL;
            end

            ST_UPD_MUL:
            begin
                prod_next  = mul_p;
                state_next = ST_UPD_WR;
            end

            ST_UPD_WR:
            begin
                done_next                = 1'b1;
                result_next.chosen_index = idx_reg;
                result_next.was_select   = 1'b0;
                state_next               = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            last_reg     <= '0;
            data_idx_reg <= '0;
            pend_reg     <= 1'b0;
            sum_reg      <= '0;
            acc_reg      <= '0;
            prod_reg     <= '0;
            op_reg       <= arsel_pkg::OP_SELECT;
            frac_reg     <= '0;
            mult_reg     <= '0;
            idx_reg      <= '0;
            done_reg     <= 1'b0;
            result_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            last_reg     <= last_next;
            data_idx_reg <= data_idx_next;
            pend_reg     <= pend_next;
            sum_reg      <= sum_next;
            acc_reg      <= acc_next;
            prod_reg     <= prod_next;
            op_reg       <= op_next;
            frac_reg     <= frac_next;
            mult_reg     <= mult_next;
            idx_reg      <= idx_next;
            done_reg     <= done_next;
            result_reg   <= result_next;
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // Checks
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !accept) |=> !done_reg)
        else $error("done held without a new transaction");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy)
        else $error("result issued while sequencer still busy");

    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (result_reg.was_select == (op_reg == arsel_pkg::OP_SELECT)))
        else $error("result kind does not match accepted operation");

    a_write_update: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr.en |-> (op_reg == arsel_pkg::OP_UPDATE))
        else $error("score table written by a select transaction");

endmodule

`default_nettype wire

FILE: tb/arsel_checker.sv
`timescale 1ns / 1ps
// Checker for the adaptive roulette selector: watches the command, result and
// register ports, predicts each result from its own score table and compares.
// Depends on arsel_pkg.
module arsel_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  arsel_pkg::in_item_t               item,
    input  logic                              done,
    input  arsel_pkg::out_item_t              result,
    input  logic                              cfg_write,
    input  logic [arsel_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [arsel_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                                pending,
    output int                                fail_count
);
    import arsel_pkg::*;

    // Shadow copy of the score table and the registers
    logic [SCORE_BITS-1:0] score_shadow [MAX_ENTRIES];
    logic [ACTIVE_W-1:0]   active_cfg;
    logic [MULT_W-1:0]     mult_best;
    logic [MULT_W-1:0]     mult_improve;
    logic [MULT_W-1:0]     mult_worse;
    out_item_t             expected_picks [$];
    int                    mismatches = 0;

    assign fail_count = mismatches;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Roulette draw over the active entries: first prefix sum reaching the target
    function automatic logic [INDEX_W-1:0] roulette_entry(input logic [FRACTION_W-1:0] fraction);
        int          n;
        int          k;
        logic [63:0] total;
        logic [63:0] running;
        logic [63:0] target;
        n = int'(active_cfg);
        if (n == 0)
            n = 1;
        if (n > MAX_ENTRIES)
            n = MAX_ENTRIES;
        total = '0;
        for (k = 0; k < n; k++)
            total += 64'(score_shadow[k]);
        target  = (total * 64'(fraction)) >> FRACTION_W;
        running = '0;
        for (k = 0; k < n; k++)
        begin
            running += 64'(score_shadow[k]);
            if (target <= running)
                return INDEX_W'(k);
        end
        return INDEX_W'(n - 1);
    endfunction

    // Q8.16 score times Q4.12 factor, clamped to [1 LSB, full scale]
    function automatic logic [SCORE_BITS-1:0] scaled_score(input logic [SCORE_BITS-1:0] score,
                                                           input logic [MULT_W-1:0] mult);
        logic [63:0] product;
        product = (64'(score) * 64'(mult)) >> MULT_FRAC_BITS;
        if (product > 64'(SCORE_MAX))
            return SCORE_MAX;
        if (product == 64'd0)
            return SCORE_BITS'(1);
        return SCORE_BITS'(product);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_item_t             want;
        logic [INDEX_W-1:0]    slot;
        int                    k;
        if (!rst_n)
        begin
            for (k = 0; k < MAX_ENTRIES; k++)
                score_shadow[k] = SCORE_ONE;
            active_cfg   = ACTIVE_RESET;
            mult_best    = MULT_RESET;
            mult_improve = MULT_RESET;
            mult_worse   = MULT_RESET;
            expected_picks.delete();
            pending <= 0;
        end
        else
        begin
            // Result side first: it always answers an earlier transaction
            if (done)
            begin
                if (expected_picks.size() == 0)
                    report_mismatch($sformatf("result index %0d with nothing outstanding",
                                              result.chosen_index));
                else
                begin
                    want = expected_picks.pop_front();
                    if (result.chosen_index !== want.chosen_index)
                        report_mismatch($sformatf("chosen_index expected %0d, got %0d",
                                                  want.chosen_index, result.chosen_index));
                    if (result.was_select !== want.was_select)
                        report_mismatch($sformatf("was_select expected %0b, got %0b",
                                                  want.was_select, result.was_select));
                end
            end

            // Register writes
            if (cfg_write)
            begin
                case (cfg_addr)
                    REG_ACTIVE_COUNT: active_cfg   = cfg_data[ACTIVE_W-1:0];
                    REG_BEST_MULT:    mult_best    = cfg_data[MULT_W-1:0];
                    REG_IMPROVE_MULT: mult_improve = cfg_data[MULT_W-1:0];
                    REG_WORSE_MULT:   mult_worse   = cfg_data[MULT_W-1:0];
                    default: ;
                endcase
            end

            // Accepted command: predict its result
            if (start && !busy)
            begin
                if (item.operation == OP_SELECT)
                begin
                    want.chosen_index = roulette_entry(item.random_fraction);
                    want.was_select   = 1'b1;
                end
                else
                begin
                    slot = item.entry_index;
                    case (item.outcome)
                        OUT_BEST:
                            score_shadow[slot] = scaled_score(score_shadow[slot], mult_best);
                        OUT_IMPROVE:
                            score_shadow[slot] = scaled_score(score_shadow[slot], mult_improve);
                        OUT_WORSE:
                            score_shadow[slot] = scaled_score(score_shadow[slot], mult_worse);
                        default: ;  // no outcome: score untouched
                    endcase
                    want.chosen_index = slot;
                    want.was_select   = 1'b0;
                end
                expected_picks = {expected_picks, want};
            end
            pending <= expected_picks.size();
        end
    end

endmodule

FILE: tb/tb_adaptive_roulette_selector.sv
`timescale 1ns / 1ps
// Top of the adaptive roulette selector testbench: clock, reset, register
// setup and command stimulus. Depends on arsel_pkg, arsel_checker and the DUT.
module tb_adaptive_roulette_selector;
    import arsel_pkg::*;

    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 119;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    in_item_t              item;
    logic                  done;
    out_item_t             result;
    logic                  cfg_write;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    pending;
    int                    fail_count;
    int                    idle_odds;

    always #4 clk = ~clk;

    adaptive_roulette_selector DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    arsel_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .item       (item),
        .done       (done),
        .result     (result),
        .cfg_write  (cfg_write),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .fail_count (fail_count)
    );

    function automatic in_item_t select_cmd(input logic [FRACTION_W-1:0] fraction);
        in_item_t cmd;
        cmd.operation       = OP_SELECT;
        cmd.random_fraction = fraction;
        cmd.entry_index     = INDEX_W'($urandom);
        cmd.outcome         = OUTCOME_W'($urandom);
        return cmd;
    endfunction

    function automatic in_item_t update_cmd(input logic [INDEX_W-1:0] slot,
                                            input logic [OUTCOME_W-1:0] outcome);
        in_item_t cmd;
        cmd.operation       = OP_UPDATE;
        cmd.random_fraction = FRACTION_W'($urandom);
        cmd.entry_index     = slot;
        cmd.outcome         = outcome;
        return cmd;
    endfunction

    // Random command: half selects, half updates; the no-outcome code is rare
    function automatic in_item_t random_cmd();
        logic [FRACTION_W-1:0] fraction;
        logic [OUTCOME_W-1:0]  outcome;
        case ($urandom_range(0, 15))
            0:       fraction = '0;
            1:       fraction = '1;
            default: fraction = FRACTION_W'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2: outcome = OUT_BEST;
            3, 4, 5: outcome = OUT_IMPROVE;
            6, 7, 8: outcome = OUT_WORSE;
            default: outcome = OUT_NONE;
        endcase
        if ($urandom_range(0, 1) == 0)
            return select_cmd(fraction);
        return update_cmd(INDEX_W'($urandom_range(0, MAX_ENTRIES - 1)), outcome);
    endfunction

    // Present one command and hold it until accepted; start stays high on return
    task automatic issue(input in_item_t cmd);
        start <= 1'b1;
        item  <= cmd;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic maybe_idle();
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // Stop sending and wait for every outstanding result
    task automatic wait_idle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0 || busy);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic program_regs(input logic [ACTIVE_W-1:0] active, input logic [MULT_W-1:0] best,
                                input logic [MULT_W-1:0] improve, input logic [MULT_W-1:0] worse);
        write_reg(REG_ACTIVE_COUNT, CFG_DATA_W'(active));
        write_reg(REG_BEST_MULT, best);
        write_reg(REG_IMPROVE_MULT, improve);
        write_reg(REG_WORSE_MULT, worse);
        cfg_write <= 1'b0;
    endtask

    // Per-phase register setting: mostly gentle factors, sometimes extremes
    task automatic random_setup();
        logic [ACTIVE_W-1:0] active;
        logic [MULT_W-1:0]   best;
        logic [MULT_W-1:0]   improve;
        logic [MULT_W-1:0]   worse;
        case ($urandom_range(0, 5))
            0:       active = ACTIVE_W'(1);
            1:       active = ACTIVE_W'(MAX_ENTRIES);
            2:       active = '0;
            3:       active = ACTIVE_W'($urandom_range(MAX_ENTRIES + 1, 63));
            default: active = ACTIVE_W'($urandom_range(2, MAX_ENTRIES - 1));
        endcase
        case ($urandom_range(0, 5))
            0:
            begin
                best    = MULT_W'($urandom);
                improve = MULT_W'($urandom);
                worse   = MULT_W'($urandom);
            end
            1:
            begin
                best    = '1;
                improve = MULT_W'($urandom_range(4096, 65535));
                worse   = '0;
            end
            default:
            begin
                best    = MULT_W'($urandom_range(4096, 8192));
                improve = MULT_W'($urandom_range(4096, 6144));
                worse   = MULT_W'($urandom_range(1024, 4096));
            end
        endcase
        program_regs(active, best, improve, worse);
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        start     <= 1'b0;
        item      <= '0;
        cfg_write <= 1'b0;
        cfg_addr  <= '0;
        cfg_data  <= '0;
        idle_odds = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset setting, fraction extremes, best, worse and no-outcome updates
        issue(select_cmd('0));
        issue(select_cmd('1));
        issue(select_cmd(16'h8000));
        issue(update_cmd(5'd0, OUT_BEST));
        issue(update_cmd(5'd31, OUT_WORSE));
        issue(update_cmd(5'd5, OUT_NONE));

        // Few active entries; an update beyond the active range still lands
        wait_idle();
        program_regs(6'd5, 16'd8192, 16'd6144, 16'd2048);
        issue(update_cmd(5'd2, OUT_BEST));
        issue(update_cmd(5'd2, OUT_IMPROVE));
        issue(update_cmd(5'd0, OUT_WORSE));
        issue(update_cmd(5'd31, OUT_BEST));
        issue(select_cmd('0));
        issue(select_cmd('1));
        issue(select_cmd(16'h4000));

        // Zero active count acts as one; zero factor floors at one LSB,
        // full-scale factor drives a score into saturation
        wait_idle();
        program_regs('0, '1, 16'd4096, '0);
        issue(select_cmd('1));
        issue(select_cmd('0));
        issue(update_cmd(5'd1, OUT_WORSE));
        issue(select_cmd(16'h8000));
        issue(update_cmd(5'd3, OUT_BEST));
        issue(update_cmd(5'd3, OUT_BEST));
        issue(update_cmd(5'd3, OUT_BEST));

        // Active count above the table depth is clipped
        wait_idle();
        program_regs('1, '1, 16'd4096, '0);
        issue(select_cmd('1));
        issue(select_cmd(16'h0001));
        issue(select_cmd(16'h8000));
        issue(update_cmd(5'd3, OUT_WORSE));
        issue(select_cmd('1));

        // Random phases; the last one runs without idling
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            random_setup();
            case ($urandom_range(0, 3))
                0:       idle_odds = 0;
                1:       idle_odds = 2;
                2:       idle_odds = 4;
                default: idle_odds = 8;
            endcase
            if (phase == PHASES - 1)
                idle_odds = 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                issue(random_cmd());
                maybe_idle();
            end
        end

        wait_idle();
        repeat (80) @(posedge clk);
        if (fail_count == 0)
            $display("tb_adaptive_roulette_selector passed");
        else
            $display("tb_adaptive_roulette_selector failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #6_000_000;
        $display("tb_adaptive_roulette_selector failed");
        $finish;
    end

endmodule

FILE: adaptive_roulette_selector.f
hdl/arsel_pkg.sv
hdl/arsel_score_mem.sv
hdl/adaptive_roulette_selector.sv
tb/arsel_checker.sv
tb/tb_adaptive_roulette_selector.sv
